// ===== hdl/mmul_pkg.sv =====
// Shared constants, item types and sequencer states for the 4x4 matrix multiplier.
// No dependencies; mmul_mac and multiply_matrices_4x4 refer to this package by scoped names.
package mmul_pkg;

  // Matrix geometry and number format (signed Q(32-FRAC_BITS).FRAC_BITS)
  localparam int DIM       = 4;
  localparam int FRAC_BITS = 16;
  localparam int CELLS     = DIM * DIM;
  localparam int DIM_W     = $clog2(DIM);
  localparam int CELL_W    = $clog2(CELLS);
  localparam int IDX_W     = 4;
  localparam int WORD_W    = 32;
  localparam int PROD_W    = 2 * WORD_W;
  localparam int TERM_W    = PROD_W - FRAC_BITS;
  localparam int ACC_W     = TERM_W + DIM_W + 1;

  // Input item
  typedef struct packed {
    logic [IDX_W-1:0]         element_index;
    logic signed [WORD_W-1:0] left_element;
    logic signed [WORD_W-1:0] right_element;
    logic                     compute_now;
  } request_t;

  // Result item
  typedef struct packed {
    logic signed [WORD_W-1:0] product_element;
    logic [IDX_W-1:0]         product_index;
    logic                     saturated;
    logic                     last_result;
  } result_t;

  // Control that travels with each multiply-accumulate step
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [CELL_W-1:0] elem;
  } tag_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

endpackage

// ===== hdl/mmul_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for both operand matrices.
module mmul_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/mmul_mac.sv =====
// Shared multiply-accumulate datapath: registered 32x32 multiply, shift and
// accumulate, then saturation into the result register. Depends on mmul_pkg.
module mmul_mac (
  input  logic                             clk,
  input  logic                             rst,
  input  logic signed [mmul_pkg::WORD_W-1:0] left_op,
  input  logic signed [mmul_pkg::WORD_W-1:0] right_op,
  input  mmul_pkg::tag_t                   tag,
  output logic                             pending,
  output mmul_pkg::result_t                result,
  output logic                             valid
);

  localparam int TERM_W = mmul_pkg::TERM_W;
  localparam int ACC_W  = mmul_pkg::ACC_W;
  localparam int WORD_W = mmul_pkg::WORD_W;

  logic signed [mmul_pkg::PROD_W-1:0] prod;
  mmul_pkg::tag_t                     prod_tag;
  logic signed [ACC_W-1:0]            acc;
  logic signed [ACC_W-1:0]            acc_next;
  logic signed [TERM_W-1:0]           term;
  logic                               sum_done;
  logic [mmul_pkg::CELL_W-1:0]        sum_cell;
  logic [ACC_W-WORD_W:0]              acc_top;
  logic                               in_range;
  mmul_pkg::result_t                  result_next;

  // Multiply stage
  always_ff @(posedge clk) begin
    prod <= left_op * right_op;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_tag <= '0;
    end else begin
      prod_tag <= tag;
    end
  end

  // Floor shift of the product, then accumulate exactly
  assign term     = prod[mmul_pkg::PROD_W-1:mmul_pkg::FRAC_BITS];
  assign acc_next = (prod_tag.first ? {ACC_W{1'b0}} : acc)
                  + {{(ACC_W-TERM_W){term[TERM_W-1]}}, term};

  always_ff @(posedge clk) begin
    if (prod_tag.valid) begin
      acc      <= acc_next;
      sum_cell <= prod_tag.elem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_done <= 1'b0;
    end else begin
      sum_done <= prod_tag.valid & prod_tag.last;
    end
  end

  // Saturate the finished sum to 32 bits
  assign acc_top  = acc[ACC_W-1:WORD_W-1];
  assign in_range = (&acc_top) | ~(|acc_top);

  always_comb begin
    result_next.product_index = mmul_pkg::IDX_W'(sum_cell);
    result_next.last_result   = (32'(sum_cell) == 32'(mmul_pkg::CELLS - 1));
    result_next.saturated     = ~in_range;
    if (in_range) begin
      result_next.product_element = acc[WORD_W-1:0];
    end else if (acc[ACC_W-1]) begin
      result_next.product_element = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      result_next.product_element = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (sum_done) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= sum_done;
    end
  end

  assign pending = prod_tag.valid;

endmodule

// ===== hdl/multiply_matrices_4x4.sv =====
// 4x4 signed Q16.16 matrix multiplier: top level with operand RAMs and sequencer.
// Depends on mmul_pkg, mmul_ram and mmul_mac.
//
// Usage:
//   An item on request is accepted at a clock edge with start high and busy low.
//   Each item writes its left and right elements at element_index into the two
//   operand RAMs (indexes of DIM*DIM or more store nothing). An item without
//   compute_now leaves busy low, and the next item may follow.
//   An item with compute_now raises busy and runs DIM^3 (64) multiply-accumulate
//   steps through one shared multiplier and adder, one step per cycle, paced by
//   the single read port of each operand RAM. The 16 product elements come out
//   row by row, each for one cycle with valid high. Busy stays high through the
//   run and a flush of the read and multiply stages; the last result is shown in
//   the first cycle with busy low, so a new item can be accepted alongside it.
//   The receiver cannot stall; results are taken the cycle they are shown.
//   Sums are exact, then clipped to 32 bits with saturated set when clipped.
//   Reset clears the sequencer and strobes; the operand RAMs are not cleared and
//   must be written before they are used in a product.
module multiply_matrices_4x4 (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mmul_pkg::request_t request,
  output logic               busy,
  output mmul_pkg::result_t  result,
  output logic               valid
);

  localparam int DIM_W  = mmul_pkg::DIM_W;
  localparam int CELL_W = mmul_pkg::CELL_W;
  localparam int WORD_W = mmul_pkg::WORD_W;

  mmul_pkg::state_t  state;
  mmul_pkg::state_t  state_next;
  logic              accept;
  logic              store_en;
  logic              issue;
  logic              last_step;
  logic [DIM_W-1:0]  row;
  logic [DIM_W-1:0]  col;
  logic [DIM_W-1:0]  k;
  logic [CELL_W-1:0] elem;
  logic [CELL_W-1:0] left_raddr;
  logic [CELL_W-1:0] right_raddr;
  logic [CELL_W-1:0] waddr;
  logic [WORD_W-1:0] left_rdata;
  logic [WORD_W-1:0] right_rdata;
  mmul_pkg::tag_t    issue_tag;
  mmul_pkg::tag_t    read_tag;
  logic              mac_pending;

  assign accept   = start & ~busy;
  assign store_en = accept & (32'(request.element_index) < 32'(mmul_pkg::CELLS));
  assign waddr    = CELL_W'(request.element_index);

  // Operand memories
  mmul_ram #(
    .WIDTH (WORD_W),
    .DEPTH (mmul_pkg::CELLS)
  ) u_left_ram (
    .clk   (clk),
    .we    (store_en),
    .waddr (waddr),
    .wdata (request.left_element),
    .raddr (left_raddr),
    .rdata (left_rdata)
  );

  mmul_ram #(
    .WIDTH (WORD_W),
    .DEPTH (mmul_pkg::CELLS)
  ) u_right_ram (
    .clk   (clk),
    .we    (store_en),
    .waddr (waddr),
    .wdata (request.right_element),
    .raddr (right_raddr),
    .rdata (right_rdata)
  );

  // Step indices: k innermost, then column, then row
  assign last_step = (row == DIM_W'(mmul_pkg::DIM - 1))
                   & (col == DIM_W'(mmul_pkg::DIM - 1))
                   & (k == DIM_W'(mmul_pkg::DIM - 1));

  assign left_raddr  = CELL_W'(row) * CELL_W'(mmul_pkg::DIM) + CELL_W'(k);
  assign right_raddr = CELL_W'(k) * CELL_W'(mmul_pkg::DIM) + CELL_W'(col);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      mmul_pkg::ST_IDLE: begin
        if (accept && request.compute_now) begin
          state_next = mmul_pkg::ST_RUN;
        end
      end
      mmul_pkg::ST_RUN: begin
        if (last_step) begin
          state_next = mmul_pkg::ST_FLUSH;
        end
      end
      mmul_pkg::ST_FLUSH: begin
        if (!read_tag.valid && !mac_pending) begin
          state_next = mmul_pkg::ST_IDLE;
        end
      end
      default: state_next = mmul_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    busy  = 1'b1;
    issue = 1'b0;
    case (state)
      mmul_pkg::ST_IDLE:  busy  = 1'b0;
      mmul_pkg::ST_RUN:   issue = 1'b1;
      mmul_pkg::ST_FLUSH: issue = 1'b0;
      default:            busy  = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mmul_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Index counters, cleared on every accept
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      row  <= '0;
      col  <= '0;
      k    <= '0;
      elem <= '0;
    end else if (issue) begin
      if (k == DIM_W'(mmul_pkg::DIM - 1)) begin
        k    <= '0;
        elem <= elem + CELL_W'(1);
        if (col == DIM_W'(mmul_pkg::DIM - 1)) begin
          col <= '0;
          row <= row + DIM_W'(1);
        end else begin
          col <= col + DIM_W'(1);
        end
      end else begin
        k <= k + DIM_W'(1);
      end
    end
  end

  // Tag is registered so that it lines up with the registered RAM read data
  always_comb begin
    issue_tag.valid = issue;
    issue_tag.first = (k == '0);
    issue_tag.last  = (k == DIM_W'(mmul_pkg::DIM - 1));
    issue_tag.elem  = elem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_tag <= '0;
    end else begin
      read_tag <= issue_tag;
    end
  end

  mmul_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .left_op  (left_rdata),
    .right_op (right_rdata),
    .tag      (read_tag),
    .pending  (mac_pending),
    .result   (result),
    .valid    (valid)
  );

  // A result only ever follows a busy cycle
  assert property (@(posedge clk) disable iff (rst) valid |-> $past(busy))
    else $error("result strobe without a preceding busy cycle");

  // The final element is never followed directly by another result
  assert property (@(posedge clk) disable iff (rst)
    (valid && result.last_result) |=> !valid)
    else $error("result strobe right after the final element");

  // A compute request always makes the block busy
  assert property (@(posedge clk) disable iff (rst)
    (accept && request.compute_now) |=> busy)
    else $error("compute request accepted but block not busy");

  // While idle, the only result shown is the final element
  assert property (@(posedge clk) disable iff (rst)
    (valid && !busy) |-> result.last_result)
    else $error("non-final result shown while idle");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for multiply_matrices_4x4: stores random and extreme
// Q16.16 operands, predicts every product element and compares it field by field.
// Depends on mmul_pkg and the multiply_matrices_4x4 RTL.
module tb_top;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 12;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  mmul_pkg::request_t request = '0;
  logic               busy;
  mmul_pkg::result_t  result;
  logic               valid;

  multiply_matrices_4x4 dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .result(result),
    .valid(valid)
  );

  // Shadow copies of both operand stores
  logic signed [mmul_pkg::WORD_W-1:0] left_shadow [mmul_pkg::CELLS];
  logic signed [mmul_pkg::WORD_W-1:0] right_shadow [mmul_pkg::CELLS];

  // Product elements still to come, oldest first
  mmul_pkg::result_t pending_products [$];

  int errors = 0;
  int items_sent = 0;
  int products_requested = 0;
  int elements_checked = 0;
  int clipped_seen = 0;
  int cycles = 0;
  int burst_left = 0;

  // Corner operand values
  logic signed [mmul_pkg::WORD_W-1:0] corner_values [8] = '{
    32'sh7FFFFFFF, 32'sh80000000, 32'sh00000000, 32'sh00000001,
    32'shFFFFFFFF, 32'sh00010000, 32'shFFFF0000, 32'sh00008000
  };

  always #5 clk = ~clk;

  // Run-away guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // Work out all 16 product elements from the shadow stores and queue them
  task automatic queue_matrix_product();
    logic signed [mmul_pkg::PROD_W-1:0] full_prod;
    logic signed [mmul_pkg::TERM_W-1:0] term;
    logic signed [65:0]                 acc;
    mmul_pkg::result_t                  expected;
    int                                 elem_num;
    for (int row = 0; row < mmul_pkg::DIM; row++) begin
      for (int col = 0; col < mmul_pkg::DIM; col++) begin
        acc = '0;
        for (int k = 0; k < mmul_pkg::DIM; k++) begin
          full_prod = left_shadow[row*mmul_pkg::DIM + k]
                    * right_shadow[k*mmul_pkg::DIM + col];
          term = full_prod >>> mmul_pkg::FRAC_BITS;
          acc = acc + term;
        end
        elem_num = row * mmul_pkg::DIM + col;
        expected.product_index = elem_num[mmul_pkg::IDX_W-1:0];
        expected.last_result = (elem_num == mmul_pkg::CELLS - 1);
        if (acc > 66'sd2147483647) begin
          expected.product_element = 32'sh7FFFFFFF;
          expected.saturated = 1'b1;
        end else if (acc < -(66'sd2147483648)) begin
          expected.product_element = 32'sh80000000;
          expected.saturated = 1'b1;
        end else begin
          expected.product_element = acc[mmul_pkg::WORD_W-1:0];
          expected.saturated = 1'b0;
        end
        pending_products.push_back(expected);
      end
    end
  endtask

  // Hold start low as a pause whose length is set by n
  task automatic sender_pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // Present one item, wait for it to be taken, then update the predictor
  task automatic send_item(input mmul_pkg::request_t item);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      case ($urandom_range(0, 5))
        0, 1: ;
        2:       sender_pause($urandom_range(20, 80));
        default: sender_pause($urandom_range(1, 6));
      endcase
    end
    burst_left--;
    @(negedge clk);
    start <= 1'b1;
    request <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (item.element_index < mmul_pkg::CELLS) begin
      left_shadow[item.element_index] = item.left_element;
      right_shadow[item.element_index] = item.right_element;
    end
    if (item.compute_now) begin
      products_requested++;
      queue_matrix_product();
    end
  endtask

  // Operand drawn from one of several value classes
  function automatic logic signed [mmul_pkg::WORD_W-1:0] pick_operand();
    logic signed [mmul_pkg::WORD_W-1:0] v;
    case ($urandom_range(0, 6))
      0, 1: v = $urandom;
      2:    v = $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      3:    v = 32'sh00010000 + $signed($urandom_range(0, 32'h1FF)) - 32'sh100;
      4:    v = corner_values[$urandom_range(0, 7)];
      5:    v = $signed($urandom) >>> $urandom_range(4, 12);
      default: v = -(32'sh00010000) + $signed($urandom_range(0, 32'hFFF)) - 32'sh800;
    endcase
    return v;
  endfunction

  // Store every cell with corner values, computing on the last one
  task automatic test_corner_fill();
    mmul_pkg::request_t item;
    for (int i = 0; i < mmul_pkg::CELLS; i++) begin
      item.element_index = i[mmul_pkg::IDX_W-1:0];
      item.left_element = corner_values[i % 8];
      item.right_element = corner_values[(i * 3 + 1) % 8];
      item.compute_now = (i == mmul_pkg::CELLS - 1);
      send_item(item);
    end
  endtask

  // Single cell updates with compute: both saturation directions, truncation of
  // a negative term, a zero row
  task automatic test_corner_cells();
    mmul_pkg::request_t item;
    item = '{element_index: 4'd0, left_element: 32'sh80000000,
             right_element: 32'sh80000000, compute_now: 1'b1};
    send_item(item);
    item = '{element_index: 4'd5, left_element: 32'sh00000001,
             right_element: 32'shFFFFFFFF, compute_now: 1'b1};
    send_item(item);
    item = '{element_index: 4'd15, left_element: 32'sh7FFFFFFF,
             right_element: 32'sh80000000, compute_now: 1'b1};
    send_item(item);
    for (int i = 8; i < 12; i++) begin
      item = '{element_index: i[mmul_pkg::IDX_W-1:0], left_element: '0,
               right_element: 32'sh7FFFFFFF, compute_now: (i == 11)};
      send_item(item);
    end
  endtask

  // Whole matrices loaded in row-major order, product on the last item
  task automatic test_random_matrices(input int matrices);
    mmul_pkg::request_t item;
    for (int m = 0; m < matrices; m++) begin
      for (int i = 0; i < mmul_pkg::CELLS; i++) begin
        item.element_index = i[mmul_pkg::IDX_W-1:0];
        item.left_element = pick_operand();
        item.right_element = pick_operand();
        item.compute_now = (i == mmul_pkg::CELLS - 1);
        send_item(item);
      end
    end
  endtask

  // Scattered single-cell writes with occasional products
  task automatic test_random_updates(input int count);
    mmul_pkg::request_t item;
    int                 idx;
    for (int n = 0; n < count; n++) begin
      idx = $urandom_range(0, mmul_pkg::CELLS - 1);
      item.element_index = idx[mmul_pkg::IDX_W-1:0];
      item.left_element = pick_operand();
      item.right_element = pick_operand();
      item.compute_now = ($urandom_range(0, 5) == 0) || (n == count - 1);
      send_item(item);
    end
  endtask

  // Compare every shown product element with the oldest expectation
  always @(posedge clk) begin
    mmul_pkg::result_t expected;
    if (!rst && valid) begin
      if (pending_products.size() == 0) begin
        $error("product element with nothing expected: index %0d value %h",
               result.product_index, result.product_element);
        errors++;
      end else begin
        expected = pending_products.pop_front();
        elements_checked++;
        if (expected.saturated) clipped_seen++;
        if (result.product_element !== expected.product_element) begin
          $error("product_element: expected %h, got %h",
                 expected.product_element, result.product_element);
          errors++;
        end
        if (result.product_index !== expected.product_index) begin
          $error("product_index: expected %0d, got %0d",
                 expected.product_index, result.product_index);
          errors++;
        end
        if (result.saturated !== expected.saturated) begin
          $error("saturated: expected %b, got %b", expected.saturated, result.saturated);
          errors++;
        end
        if (result.last_result !== expected.last_result) begin
          $error("last_result: expected %b, got %b",
                 expected.last_result, result.last_result);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_corner_fill();
    test_corner_cells();
    test_random_matrices(12);
    test_random_updates(210);
    sender_pause(1);

    while (pending_products.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb_top: %0d items sent, %0d products requested", items_sent, products_requested);
    $display("tb_top: %0d elements checked, %0d of them clipped", elements_checked,
             clipped_seen);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
